// ===== sv/mesp_pkg.sv =====
package mesp_pkg;

    localparam int unsigned HDR_END   = 44;
    localparam int unsigned TDATA_W   = 160;

    localparam logic [7:0] TYPE_LAPIC  = 8'd0;
    localparam logic [7:0] TYPE_ADDR   = 8'd5;
    localparam logic [7:0] TYPE_X2APIC = 8'd9;

    localparam logic [31:0] OFF_MAX = 32'hFFFF_FFFF;

    typedef enum logic {
        KIND_CPU     = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_SHORT_LEN = 2'd1,
        ST_TRUNC     = 2'd2
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  cpu_index;
        logic [7:0]  processor_uid;
        logic [7:0]  local_apic_id;
        logic [31:0] processor_flags;
        logic [63:0] lapic_address;
        logic [31:0] table_flags;
        logic [4:0]  processors_found;
        logic [1:0]  status;
        logic        last_of_run;
    } result_t;

endpackage

// ===== sv/madt_entry_stream_parser_top.sv =====
// MADT entry stream parser.
// Input channel s_*: one table byte per word in s_tdata, s_tlast on the final
// byte of the table. Result channel m_*: m_tuser is the kind (0 processor
// record, 1 end-of-table summary), m_tlast marks the last result caused by one
// input word, m_tdata carries the record and summary fields.
// Each accepted byte updates the header and entry state in the cycle it is
// taken and writes its results (none, one or two) into a three-entry output
// queue. A result is registered into that queue as its byte is accepted.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
// closes a processor entry on the final byte yields two results, which leave
// the queue in turn. s_tready is high while at most one result is queued, so
// a stalled receiver stops the input once two results wait.
// Reset (aresetn low at a clock edge) empties the queue and returns all
// parsing state to the start of a table; no clearing pass is needed. After the
// final byte the parser returns to that same state for the next table.
// MAX_CPUS bounds the number of processor records kept per table.
module madt_entry_stream_parser_top
    import mesp_pkg::*;
#(
    parameter int unsigned MAX_CPUS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [3:0] cpu_index, [11:4] processor_uid, [19:12] local_apic_id,
    // [51:20] processor_flags, [115:52] lapic_address, [147:116] table_flags,
    // [152:148] processors_found, [154:153] status, [159:155] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,   // [0] kind
    output logic               m_tlast
);

    localparam int unsigned CNT_W = $clog2(MAX_CPUS + 1);

    logic [31:0]      off_reg;
    logic [31:0]      hdr_len_reg, hdr_len_next;
    logic [7:0]       ent_off_reg, ent_off_next;
    logic [7:0]       ent_type_reg, ent_type_next;
    logic [7:0]       ent_len_reg, ent_len_next;
    logic [63:0]      gather_reg, gather_next;
    logic [7:0]       uid_reg, uid_next;
    logic [7:0]       apic_reg, apic_next;
    logic [31:0]      rflags_reg, rflags_next;
    logic [63:0]      lapic_reg, lapic_next;
    logic [31:0]      tflags_reg, tflags_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       stop_reg, stop_next;

    logic             in_acc;
    logic [7:0]       b;
    logic [7:0]       ent_pos_inc;
    logic [2:0]       addr_lane;
    logic             in_entries;
    logic             finish;
    logic             emit;
    logic [CNT_W+4:0] cnt_cur_ext, cnt_next_ext;
    logic [32:0]      off_plus1;
    logic [32:0]      ent_end;
    status_t          sum_status;
    result_t          rec_res, sum_res;

    // output queue
    result_t          q_mem [3];
    logic [1:0]       rd_ptr_reg, wr_ptr_reg, q_cnt_reg;
    logic [1:0]       n_push;
    logic             pop;
    result_t          head;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign in_acc      = s_tvalid && s_tready;
    assign b           = s_tdata;
    assign off_plus1   = {1'b0, off_reg} + 33'd1;
    assign ent_end     = {1'b0, off_reg} - 33'd1 + {25'd0, b};
    assign ent_pos_inc = ent_off_reg + 8'd1;
    assign addr_lane   = 3'(ent_off_reg - 8'd4);
    assign in_entries  = (stop_reg == 2'(ST_COMPLETE)) && (off_reg != OFF_MAX)
                         && (off_reg < hdr_len_reg);

    always_comb begin
        hdr_len_next  = hdr_len_reg;
        ent_off_next  = ent_off_reg;
        ent_type_next = ent_type_reg;
        ent_len_next  = ent_len_reg;
        gather_next   = gather_reg;
        uid_next      = uid_reg;
        apic_next     = apic_reg;
        rflags_next   = rflags_reg;
        lapic_next    = lapic_reg;
        tflags_next   = tflags_reg;
        stop_next     = stop_reg;
        finish        = 1'b0;

        if (off_reg < 32'(HDR_END)) begin
            if (off_reg >= 32'd4 && off_reg <= 32'd7) begin
                hdr_len_next[off_reg[1:0]*8 +: 8] = b;
            end else if (off_reg >= 32'd36 && off_reg <= 32'd39) begin
                lapic_next[off_reg[1:0]*8 +: 8] = b;
            end else if (off_reg >= 32'd40) begin
                tflags_next[off_reg[1:0]*8 +: 8] = b;
            end
        end else if (in_entries) begin
            if (ent_off_reg == 8'd0) begin
                // start an entry only if its length byte is inside the table
                if (off_plus1 < {1'b0, hdr_len_reg}) begin
                    ent_type_next = b;
                    ent_off_next  = 8'd1;
                    gather_next   = '0;
                    uid_next      = '0;
                    apic_next     = '0;
                    rflags_next   = '0;
                end
            end else if (ent_off_reg == 8'd1) begin
                if (b < 8'd2) begin
                    stop_next    = 2'(ST_SHORT_LEN);
                    ent_off_next = 8'd0;
                end else if (ent_end > {1'b0, hdr_len_reg}) begin
                    stop_next    = 2'(ST_TRUNC);
                    ent_off_next = 8'd0;
                end else begin
                    ent_len_next = b;
                    // a two-byte entry has no body and never makes a record
                    ent_off_next = (b == 8'd2) ? 8'd0 : 8'd2;
                end
            end else begin
                case (ent_type_reg)
                    TYPE_LAPIC: begin
                        if (ent_off_reg == 8'd2) begin
                            uid_next = b;
                        end else if (ent_off_reg == 8'd3) begin
                            apic_next = b;
                        end else if (ent_off_reg >= 8'd4 && ent_off_reg <= 8'd7) begin
                            rflags_next[ent_off_reg[1:0]*8 +: 8] = b;
                        end
                    end
                    TYPE_ADDR: begin
                        if (ent_off_reg >= 8'd4 && ent_off_reg <= 8'd11) begin
                            gather_next[addr_lane*8 +: 8] = b;
                        end
                    end
                    TYPE_X2APIC: begin
                        if (ent_off_reg == 8'd4) begin
                            apic_next = b;
                        end else if (ent_off_reg >= 8'd8 && ent_off_reg <= 8'd11) begin
                            rflags_next[ent_off_reg[1:0]*8 +: 8] = b;
                        end else if (ent_off_reg == 8'd12) begin
                            uid_next = b;
                        end
                    end
                    default: begin
                    end
                endcase
                ent_off_next = ent_pos_inc;
                if (ent_pos_inc >= ent_len_reg) begin
                    finish       = 1'b1;
                    ent_off_next = 8'd0;
                    if (ent_type_reg == TYPE_ADDR && ent_len_reg >= 8'd12) begin
                        lapic_next = gather_next;
                    end
                end
            end
        end

        emit = finish && (count_reg < CNT_W'(MAX_CPUS)) &&
               ((ent_type_reg == TYPE_LAPIC && ent_len_reg >= 8'd8) ||
                (ent_type_reg == TYPE_X2APIC && ent_len_reg >= 8'd16));
        count_next = emit ? count_reg + CNT_W'(1) : count_reg;
    end

    assign cnt_cur_ext  = (CNT_W+5)'(count_reg);
    assign cnt_next_ext = (CNT_W+5)'(count_next);

    always_comb begin
        sum_status = status_t'(stop_next);
        if (stop_next == 2'(ST_COMPLETE) &&
            (off_plus1 < 33'(HDR_END) || off_plus1 < {1'b0, hdr_len_next})) begin
            sum_status = ST_TRUNC;
        end

        rec_res                 = '0;
        rec_res.kind            = KIND_CPU;
        rec_res.cpu_index       = cnt_cur_ext[3:0];
        rec_res.processor_uid   = uid_next;
        rec_res.local_apic_id   = apic_next;
        rec_res.processor_flags = rflags_next;
        rec_res.last_of_run     = !s_tlast;

        sum_res                  = '0;
        sum_res.kind             = KIND_SUMMARY;
        sum_res.lapic_address    = lapic_next;
        sum_res.table_flags      = tflags_next;
        sum_res.processors_found = cnt_next_ext[4:0];
        sum_res.status           = sum_status;
        sum_res.last_of_run      = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_acc && s_tlast)) begin
            off_reg      <= '0;
            hdr_len_reg  <= '0;
            ent_off_reg  <= '0;
            ent_type_reg <= '0;
            ent_len_reg  <= '0;
            gather_reg   <= '0;
            uid_reg      <= '0;
            apic_reg     <= '0;
            rflags_reg   <= '0;
            lapic_reg    <= '0;
            tflags_reg   <= '0;
            count_reg    <= '0;
            stop_reg     <= '0;
        end else if (in_acc) begin
            if (off_reg != OFF_MAX) begin
                off_reg <= off_reg + 32'd1;
            end
            hdr_len_reg  <= hdr_len_next;
            ent_off_reg  <= ent_off_next;
            ent_type_reg <= ent_type_next;
            ent_len_reg  <= ent_len_next;
            gather_reg   <= gather_next;
            uid_reg      <= uid_next;
            apic_reg     <= apic_next;
            rflags_reg   <= rflags_next;
            lapic_reg    <= lapic_next;
            tflags_reg   <= tflags_next;
            count_reg    <= count_next;
            stop_reg     <= stop_next;
        end
    end

    // queue: accept while at most one result waits, so two always fit
    assign s_tready = !q_cnt_reg[1];
    assign n_push   = in_acc ? (2'(emit) + 2'(s_tlast)) : 2'd0;
    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (emit) begin
                q_mem[wr_ptr_reg] <= rec_res;
                if (s_tlast) begin
                    q_mem[inc3(wr_ptr_reg)] <= sum_res;
                end
            end else if (s_tlast) begin
                q_mem[wr_ptr_reg] <= sum_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            if (pop) begin
                rd_ptr_reg <= inc3(rd_ptr_reg);
            end
            if (n_push == 2'd2) begin
                wr_ptr_reg <= inc3(inc3(wr_ptr_reg));
            end else if (n_push == 2'd1) begin
                wr_ptr_reg <= inc3(wr_ptr_reg);
            end
            q_cnt_reg <= q_cnt_reg + n_push - 2'(pop);
        end
    end

    assign m_tdata = {5'd0, head.status, head.processors_found, head.table_flags,
                      head.lapic_address, head.processor_flags, head.local_apic_id,
                      head.processor_uid, head.cpu_index};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

// ===== sv/mesp_checker.sv =====
module mesp_checker
    import mesp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser,
    input logic               m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a summary always closes the run of its byte, with zero record fields and a valid status
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SUMMARY) |-> m_tlast &&
        m_tdata[51:0] == 52'd0 && m_tdata[154:153] != 2'd3)
        else $error("malformed summary word");

    a_record_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CPU) |-> m_tdata[159:52] == 108'd0)
        else $error("processor record carries summary fields");

endmodule

bind madt_entry_stream_parser_top mesp_checker u_mesp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
